[src/cte_pkg.sv]
// ----------------------------------------------------------------------------
// cte_pkg
// Types, constants and calendar tables for the calendar to epoch seconds block.
// ----------------------------------------------------------------------------
`default_nettype none

package cte_pkg;

  localparam logic [11:0] BaseYear    = 12'd2000;
  localparam logic [11:0] LastYear    = 12'd2060;
  localparam logic [31:0] SecsPerDay  = 32'd86400;
  localparam logic [16:0] SecsPerHour = 17'd3600;
  localparam logic [16:0] SecsPerMin  = 17'd60;
  localparam logic [14:0] DaysPerYear = 15'd365;

  typedef struct packed {
    logic [11:0] year;
    logic [7:0]  month;
    logic [7:0]  day;
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [7:0]  second;
  } item_t;

  typedef struct packed {
    logic [30:0] seconds_since_base;
    logic        invalid;
  } result_t;

  // Checked and narrowed fields after the first stage
  typedef struct packed {
    logic       invalid;
    logic       leap;
    logic [5:0] year_off;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } chk_t;

  // Day count and time of day after the second stage
  typedef struct packed {
    logic        invalid;
    logic [14:0] days;
    logic [16:0] tod;
  } days_t;

  function automatic logic [4:0] month_len(input logic [3:0] mo, input logic leap);
    logic [4:0] len;
    case (mo)
      4'd1:    len = 5'd31;
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd3:    len = 5'd31;
      4'd4:    len = 5'd30;
      4'd5:    len = 5'd31;
      4'd6:    len = 5'd30;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd31;
      4'd9:    len = 5'd30;
      4'd10:   len = 5'd31;
      4'd11:   len = 5'd30;
      4'd12:   len = 5'd31;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] days_before_month(input logic [3:0] mo);
    logic [8:0] dbm;
    case (mo)
      4'd1:    dbm = 9'd0;
      4'd2:    dbm = 9'd31;
      4'd3:    dbm = 9'd59;
      4'd4:    dbm = 9'd90;
      4'd5:    dbm = 9'd120;
      4'd6:    dbm = 9'd151;
      4'd7:    dbm = 9'd181;
      4'd8:    dbm = 9'd212;
      4'd9:    dbm = 9'd243;
      4'd10:   dbm = 9'd273;
      4'd11:   dbm = 9'd304;
      4'd12:   dbm = 9'd334;
      default: dbm = 9'd0;
    endcase
    return dbm;
  endfunction

endpackage

`default_nettype wire

[src/cte_check.sv]
// ----------------------------------------------------------------------------
// cte_check
// First stage: range checks on every field and narrowing of the fields.
// ----------------------------------------------------------------------------
`default_nettype none

module cte_check
  import cte_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  up_valid,
  input  wire item_t up_data,
  output logic       up_ready,
  input  wire logic  down_ready,
  output logic       valid,
  output chk_t       data
);

  logic        leap;
  logic [3:0]  mo;
  logic [4:0]  len;
  logic [11:0] year_off;
  logic        year_ok;
  logic        month_ok;
  logic        day_ok;
  logic        time_ok;
  chk_t        data_next;

  always_comb begin
    leap      = (up_data.year[1:0] == 2'b00);
    mo        = up_data.month[3:0];
    year_off  = up_data.year - BaseYear;
    year_ok   = (up_data.year >= BaseYear) && (up_data.year <= LastYear);
    month_ok  = (up_data.month >= 8'd1) && (up_data.month <= 8'd12);
    len       = month_len(mo, leap);
    day_ok    = (up_data.day != 8'd0) && (up_data.day <= {3'b000, len});
    time_ok   = (up_data.hour <= 8'd23) && (up_data.minute <= 8'd59) &&
                (up_data.second <= 8'd59);

    data_next.invalid  = !(year_ok && month_ok && day_ok && time_ok);
    data_next.leap     = leap;
    data_next.year_off = year_off[5:0];
    data_next.month    = mo;
    data_next.day      = up_data.day[4:0];
    data_next.hour     = up_data.hour[4:0];
    data_next.minute   = up_data.minute[5:0];
    data_next.second   = up_data.second[5:0];
  end

  assign up_ready = !valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data <= data_next;
    end
  end

endmodule

`default_nettype wire

[src/cte_days.sv]
// ----------------------------------------------------------------------------
// cte_days
// Second stage: day count since the base date and seconds within the day.
// ----------------------------------------------------------------------------
`default_nettype none

module cte_days
  import cte_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic up_valid,
  input  wire chk_t up_data,
  output logic      up_ready,
  input  wire logic down_ready,
  output logic      valid,
  output days_t     data
);

  logic [6:0]  n_plus;
  logic [14:0] year_days;
  logic [14:0] leap_days;
  logic [14:0] month_days;
  logic [14:0] extra_day;
  logic [4:0]  day_m1;
  days_t       data_next;

  always_comb begin
    n_plus     = {1'b0, up_data.year_off} + 7'd3;
    year_days  = {9'd0, up_data.year_off} * DaysPerYear;
    leap_days  = {10'd0, n_plus[6:2]};
    month_days = {6'd0, days_before_month(up_data.month)};
    extra_day  = {14'd0, (up_data.month > 4'd2) && up_data.leap};
    day_m1     = up_data.day - 5'd1;

    data_next.invalid = up_data.invalid;
    data_next.days    = year_days + leap_days + month_days + extra_day +
                        {10'd0, day_m1};
    data_next.tod     = {12'd0, up_data.hour} * SecsPerHour +
                        {11'd0, up_data.minute} * SecsPerMin +
                        {11'd0, up_data.second};
  end

  assign up_ready = !valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data <= data_next;
    end
  end

endmodule

`default_nettype wire

[src/cte_scale.sv]
// ----------------------------------------------------------------------------
// cte_scale
// Third and fourth stages: days times seconds per day, then the final sum
// into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cte_scale
  import cte_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  up_valid,
  input  wire days_t up_data,
  output logic       up_ready,
  input  wire logic  out_stall,
  output logic       out_valid,
  output result_t    out_data
);

  logic        prod_valid;
  logic [31:0] prod;
  logic [16:0] prod_tod;
  logic        prod_invalid;
  logic        prod_ready;
  logic        out_ready;
  logic [31:0] prod_next;
  logic [30:0] total;
  result_t     out_next;

  always_comb begin
    prod_next = {17'd0, up_data.days} * SecsPerDay;
    total     = prod[30:0] + {14'd0, prod_tod};
    out_next.invalid            = prod_invalid;
    out_next.seconds_since_base = prod_invalid ? 31'd0 : total;
  end

  assign out_ready  = !out_valid || !out_stall;
  assign prod_ready = !prod_valid || out_ready;
  assign up_ready   = prod_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (prod_ready) begin
        prod_valid <= up_valid;
      end
      if (out_ready) begin
        out_valid <= prod_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (prod_ready && up_valid) begin
      prod         <= prod_next;
      prod_tod     <= up_data.tod;
      prod_invalid <= up_data.invalid;
    end
    if (out_ready && prod_valid) begin
      out_data <= out_next;
    end
  end

endmodule

`default_nettype wire

[src/calendar_to_epoch_seconds_top.sv]
// Pipeline: four register stages (check, day count, day multiply, final sum).
// Throughput: one transaction per cycle; a stall on the result side holds
// every occupied stage, and empty stages still take new transactions.
// Reset: synchronous, clears all stage valid bits; nothing else is reset.
// ----------------------------------------------------------------------------
// calendar_to_epoch_seconds_top
// Converts a checked calendar date and time into seconds since 2000-01-01.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_to_epoch_seconds_top
  import cte_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  item_valid,
  output logic       item_stall,
  input  wire item_t item,
  output logic       result_valid,
  input  wire logic  result_stall,
  output result_t    result
);

  logic  chk_ready;
  logic  chk_valid;
  chk_t  chk_data;
  logic  days_ready;
  logic  days_valid;
  days_t days_data;
  logic  scale_ready;

  assign item_stall = !chk_ready;

  cte_check u_check (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (item_valid),
    .up_data    (item),
    .up_ready   (chk_ready),
    .down_ready (days_ready),
    .valid      (chk_valid),
    .data       (chk_data)
  );

  cte_days u_days (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (chk_valid),
    .up_data    (chk_data),
    .up_ready   (days_ready),
    .down_ready (scale_ready),
    .valid      (days_valid),
    .data       (days_data)
  );

  cte_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (days_valid),
    .up_data   (days_data),
    .up_ready  (scale_ready),
    .out_stall (result_stall),
    .out_valid (result_valid),
    .out_data  (result)
  );

endmodule

`default_nettype wire
